/* src/lpxd_pkg.sv */
// Shared types and constants for the length-prefixed XOR deframer.
package lpxd_pkg;

    localparam int unsigned MAX_LEN_W  = 15;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned ARG_W      = 15;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 15;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY          = 2'd1;

    localparam logic [MAX_LEN_W-1:0] MAX_FRAME_LENGTH_RST = 15'd32763;
    localparam logic [BYTE_W-1:0]    XOR_KEY_RST          = 8'h5A;

    localparam int unsigned HDR_BYTES = 4;

    // one classified item handed from the front end to the back end
    typedef struct packed {
        logic [BYTE_W-1:0] raw;
        logic              last;
        logic              err;
    } t_token;

    typedef struct packed {
        logic   valid;
        t_token token;
    } t_qwr;

endpackage

/* src/lpxd_front.sv */
// Front end: header parsing, length check and payload byte classification.
module lpxd_front
    import lpxd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_q_full,
    input  logic [31:0] i_limit,
    output logic        o_stall,
    output t_qwr        o_qwr
);

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;
    localparam logic [1:0] PH_HALTED  = 2'd2;

    logic [1:0]           r_phase,     n_phase;
    logic [1:0]           r_hdr_cnt,   n_hdr_cnt;
    logic [23:0]          r_hdr_shift, n_hdr_shift;
    logic [MAX_LEN_W-1:0] r_remain,    n_remain;

    logic        accept;
    logic [31:0] hdr_len;
    logic        last;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign hdr_len = {i_rx_byte, r_hdr_shift};
    assign last    = (r_remain <= MAX_LEN_W'(1));

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_hdr_shift = r_hdr_shift;
        n_remain    = r_remain;
        o_qwr       = '0;
        o_qwr.token.raw = i_rx_byte;
        if (accept) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hdr_cnt != 2'(HDR_BYTES - 1)) begin
                        n_hdr_shift[{r_hdr_cnt, 3'b000} +: 8] = i_rx_byte;
                        n_hdr_cnt = r_hdr_cnt + 2'd1;
                    end else begin
                        n_hdr_cnt   = '0;
                        n_hdr_shift = '0;
                        if (hdr_len == 32'd0 || hdr_len > i_limit) begin
                            o_qwr.valid     = 1'b1;
                            o_qwr.token.err = 1'b1;
                            n_phase         = PH_HALTED;
                        end else begin
                            n_remain = hdr_len[MAX_LEN_W-1:0];
                            n_phase  = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    o_qwr.valid      = 1'b1;
                    o_qwr.token.last = last;
                    if (last) begin
                        n_remain = '0;
                        n_phase  = PH_HEADER;
                    end else begin
                        n_remain = r_remain - MAX_LEN_W'(1);
                    end
                end
                default: begin
                    // halted: bytes are taken and dropped
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_hdr_cnt   <= '0;
            r_hdr_shift <= '0;
            r_remain    <= '0;
        end else begin
            r_phase     <= n_phase;
            r_hdr_cnt   <= n_hdr_cnt;
            r_hdr_shift <= n_hdr_shift;
            r_remain    <= n_remain;
        end
    end

    a_no_push_halted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HALTED) |-> !o_qwr.valid)
        else $error("front pushed a token while halted");

    a_err_halts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_qwr.valid && o_qwr.token.err) |=> (r_phase == PH_HALTED))
        else $error("error token did not halt the front end");

endmodule

/* src/lpxd_queue.sv */
// Two-entry token queue between front end and back end.
module lpxd_queue
    import lpxd_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_qwr   i_qwr,
    input  logic   i_pop,
    output logic   o_full,
    output logic   o_valid,
    output t_token o_token
);

    t_token     r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count, n_count;

    logic push;
    logic pop;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_token = r_mem[r_rptr];
    assign push    = i_qwr.valid && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_qwr.token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= '0;
        end else begin
            if (push) r_wptr <= !r_wptr;
            if (pop)  r_rptr <= !r_rptr;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qwr.valid |-> !o_full)
        else $error("token pushed into a full queue");

endmodule

/* src/lpxd_back.sv */
// Back end: XOR decode, argument counting and output register.
module lpxd_back
    import lpxd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_valid,
    input  t_token            i_token,
    input  logic [BYTE_W-1:0] i_key,
    input  logic              i_stall,
    output logic              o_pop,
    output logic              o_valid,
    output logic [7:0]        o_data_byte,
    output logic              o_is_separator,
    output logic [14:0]       o_arg_index,
    output logic              o_frame_end,
    output logic              o_length_error
);

    logic              r_valid;
    logic [ARG_W-1:0]  r_arg_cnt, n_arg_cnt;
    logic [BYTE_W-1:0] r_data;
    logic              r_sep;
    logic [ARG_W-1:0]  r_arg_idx;
    logic              r_fend;
    logic              r_err;

    logic [BYTE_W-1:0] dec;
    logic              sep;

    assign o_pop = i_q_valid && (!r_valid || !i_stall);
    assign dec   = i_token.raw ^ i_key;
    assign sep   = (dec == '0) && !i_token.err;

    always_comb begin
        n_arg_cnt = r_arg_cnt;
        if (o_pop && !i_token.err) begin
            if (i_token.last) begin
                n_arg_cnt = '0;
            end else if (sep) begin
                n_arg_cnt = r_arg_cnt + ARG_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data    <= i_token.err ? '0 : dec;
            r_sep     <= sep;
            r_arg_idx <= i_token.err ? '0 : r_arg_cnt;
            r_fend    <= i_token.last && !i_token.err;
            r_err     <= i_token.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= 1'b0;
            r_arg_cnt <= '0;
        end else begin
            r_arg_cnt <= n_arg_cnt;
            if (o_pop) begin
                r_valid <= 1'b1;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_data_byte    = r_data;
    assign o_is_separator = r_sep;
    assign o_arg_index    = r_arg_idx;
    assign o_frame_end    = r_fend;
    assign o_length_error = r_err;

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_err) |-> (r_data == '0 && r_arg_idx == '0 && !r_fend && !r_sep))
        else $error("error result carries payload fields");

endmodule

/* src/length_prefixed_xor_deframer_unit.sv */
// Length-prefixed XOR deframer top level: config registers and front/queue/back.
// A payload byte passes the token queue and the back-end output register before it
// shows up on the output. Throughput: one byte per cycle while the queue is not full;
// while a result waits, the two-entry token queue takes two more bytes before the input
// stalls. Header bytes give no result, but a rejected length gives an error result.
// Synchronous active-low reset returns to header phase and restores register defaults.
module length_prefixed_xor_deframer_unit
    import lpxd_pkg::*;
#(
    parameter int unsigned BUFFER_BYTES = 32768
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_rx_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [7:0]            o_data_byte,
    output logic                  o_is_separator,
    output logic [14:0]           o_arg_index,
    output logic                  o_frame_end,
    output logic                  o_length_error,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic [31:0] LEN_CAP = 32'(BUFFER_BYTES - 5);

    logic [MAX_LEN_W-1:0] r_max_len;
    logic [BYTE_W-1:0]    r_key;
    logic [31:0]          limit;

    t_qwr   qwr;
    t_token q_token;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_FRAME_LENGTH_RST;
            r_key     <= XOR_KEY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MAX_FRAME_LENGTH: r_max_len <= i_cfg_data[MAX_LEN_W-1:0];
                CFG_XOR_KEY:          r_key     <= i_cfg_data[BYTE_W-1:0];
                default: begin
                    // writes beyond the register list are dropped
                end
            endcase
        end
    end

    assign limit = (32'(r_max_len) < LEN_CAP) ? 32'(r_max_len) : LEN_CAP;

    lpxd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .i_limit   (limit),
        .o_stall   (o_stall),
        .o_qwr     (qwr)
    );

    lpxd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_token (q_token)
    );

    lpxd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_valid      (q_valid),
        .i_token        (q_token),
        .i_key          (r_key),
        .i_stall        (i_stall),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .o_data_byte    (o_data_byte),
        .o_is_separator (o_is_separator),
        .o_arg_index    (o_arg_index),
        .o_frame_end    (o_frame_end),
        .o_length_error (o_length_error)
    );

endmodule
